@@ hw/rtl/upn_pkg.sv @@
// upn_pkg: shared constants, codes and control types of the uri path normalizer
// used by upn_ctrl, upn_dp and uri_path_normalizer; depends on nothing else

package upn_pkg;

  // storage sizes
  localparam int PATH_BYTES   = 1024;
  localparam int MAX_SEGMENTS = 64;

  // derived widths
  localparam int PATH_AW = $clog2(PATH_BYTES);
  localparam int POS_W   = $clog2(PATH_BYTES + 1);
  localparam int SEG_AW  = $clog2(MAX_SEGMENTS);

  // fixed field widths of the stream words
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 10;
  localparam int LEN_W    = 11;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 24;
  localparam int IDX_LSB  = BYTE_W;
  localparam int LEN_LSB  = BYTE_W;
  localparam int OVF_BIT  = LEN_LSB + LEN_W;
  localparam int BAD_BIT  = OVF_BIT + 1;

  // characters
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DIG0  = 8'd48;
  localparam logic [7:0] CH_DIG9  = 8'd57;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] HEX_UOFS = 8'd55;
  localparam logic [7:0] HEX_LOFS = 8'd87;

  // segment classes
  localparam logic [1:0] CLS_EMPTY  = 2'd0;
  localparam logic [1:0] CLS_DOT    = 2'd1;
  localparam logic [1:0] CLS_DOTDOT = 2'd2;
  localparam logic [1:0] CLS_OTHER  = 2'd3;

  // escape phases
  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  // commands from the sequencer
  typedef struct packed {
    logic accept;
    logic raw_step;
    logic finish;
    logic load_out;
  } cmd_t;

  // status back to the sequencer
  typedef struct packed {
    logic fin;
    logic out_free;
    logic ovf;
    logic uri_done;
  } status_t;

endpackage

@@ hw/rtl/uri_path_normalizer.sv @@
// uri_path_normalizer: percent decoding and dot segment removal of uri paths
// slave channel takes push or read words, master channel returns result words
// instantiates upn_ctrl and upn_dp; uses upn_pkg
//
// a push word (tuser 0) carries one raw path byte, tlast marks the last byte
// of a uri; only the last push returns a word with the normalized length and
// the sticky overflow and bad escape flags. a read word (tuser 1) returns the
// stored normalized byte at read_index together with length and flags.
// the first push after a finished uri starts a new one; the store is kept.
// one word is worked at a time and the input stays closed meanwhile: a
// non-final push passes the step state, a final push the step, finish and result
// states, a read only the result state, which loads its word; the sequencer
// does one engine update per cycle and the store and stack reads are
// registered at acceptance. a result sits in an output register, so the
// next word is accepted while it waits; while the receiver stalls, the next
// word with a result waits in the sequencer and the input stays closed.
// reset clears all control state, no clearing pass runs, and the block
// takes a word as soon as reset is released.

module uri_path_normalizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [7:0] path_byte, [17:8] read_index, [23:18] zero
  input  logic [upn_pkg::IN_DW-1:0]   s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,
  // [0] mode
  input  logic                        s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [7:0] out_byte, [18:8] out_length, [19] overflow, [20] bad_escape, [23:21] zero
  output logic [upn_pkg::OUT_DW-1:0]  m_axis_tdata_o
);

  upn_pkg::cmd_t    cmd;
  upn_pkg::status_t status;

  // sequencer
  upn_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_mode_i  (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // datapath
  upn_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .s_mode_i  (s_axis_tuser_i),
    .s_last_i  (s_axis_tlast_i),
    .s_data_i  (s_axis_tdata_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

  // a result is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result loaded over a pending word");

  // every accepted word closes the input in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted back to back");

  // reported length never exceeds the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[upn_pkg::LEN_LSB +: upn_pkg::LEN_W] <=
       upn_pkg::LEN_W'(upn_pkg::PATH_BYTES)))
    else $error("length beyond store size");

  // overflow stays set until a new uri starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.ovf && !(cmd.accept && !s_axis_tuser_i && status.uri_done)) |=> status.ovf)
    else $error("overflow flag dropped inside a uri");

endmodule

@@ hw/rtl/upn_ctrl.sv @@
// upn_ctrl: sequencer of the uri path normalizer
// uses upn_pkg for command and status types; drives the input ready

module upn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            s_mode_i,
  output logic            s_ready_o,
  input  upn_pkg::status_t status_i,
  output upn_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STEP   = 2'd1;
  localparam logic [1:0] ST_FIN    = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
        if (s_valid_i) begin
          state_d = s_mode_i ? ST_RESULT : ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.raw_step = 1'b1;
        state_d        = status_i.fin ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/upn_dp.sv @@
// upn_dp: datapath of the uri path normalizer: escape decoder, segment engine,
// path store, segment start stack and output word register; uses upn_pkg

module upn_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  upn_pkg::cmd_t               cmd_i,
  output upn_pkg::status_t            status_o,
  input  logic                        s_mode_i,
  input  logic                        s_last_i,
  input  logic [upn_pkg::IN_DW-1:0]   s_data_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [upn_pkg::OUT_DW-1:0]  m_data_o
);

  // storage
  logic [7:0]                   path_mem [upn_pkg::PATH_BYTES];
  logic [upn_pkg::POS_W-1:0]    stk_mem  [upn_pkg::MAX_SEGMENTS];

  // captured item
  logic                         mode_q;
  logic                         fin_q;
  logic [7:0]                   byte_q;
  logic [7:0]                   rd_data_q;
  logic                         rd_ok_q;
  logic [upn_pkg::POS_W-1:0]    below_q;

  // engine state
  logic [upn_pkg::POS_W-1:0]    wpos_q, wpos_d;
  logic [upn_pkg::POS_W-1:0]    cur_q, cur_d;
  logic [upn_pkg::SEG_AW-1:0]   depth_q, depth_d;
  logic [1:0]                   esc_q, esc_d;
  logic [3:0]                   high_q, high_d;
  logic [1:0]                   cls_q, cls_d;
  logic                         slashed_q, slashed_d;
  logic                         ovf_q, ovf_d;
  logic                         bad_q, bad_d;
  logic                         done_q, done_d;

  // output word
  logic                         out_valid_q;
  logic [upn_pkg::OUT_DW-1:0]   out_data_q;

  // combinational helpers
  logic [7:0]                   in_byte;
  logic [upn_pkg::IDX_W-1:0]    in_idx;
  logic [upn_pkg::PATH_AW-1:0]  rd_addr;
  logic                         rd_ok;
  logic [upn_pkg::SEG_AW-1:0]   stk_rd_addr;
  logic [3:0]                   hex_val;
  logic                         hex_ok;
  logic                         seg_en;
  logic [7:0]                   seg_b;
  logic [upn_pkg::POS_W-1:0]    p;
  logic                         st_en;
  logic [upn_pkg::POS_W-1:0]    st_pos;
  logic [7:0]                   st_b;
  logic                         pw_en;
  logic                         sk_we;
  logic                         stk_full;
  logic                         cls_dots;
  logic [7:0]                   out_byte;

  assign in_byte     = s_data_i[7:0];
  assign in_idx      = s_data_i[upn_pkg::IDX_LSB +: upn_pkg::IDX_W];
  assign rd_addr     = upn_pkg::PATH_AW'(32'(in_idx));
  assign rd_ok       = 32'(in_idx) < 32'(upn_pkg::PATH_BYTES);
  assign stk_rd_addr = depth_q - 1'b1;
  assign stk_full    = depth_q == upn_pkg::SEG_AW'(upn_pkg::MAX_SEGMENTS - 1);
  assign cls_dots    = (cls_q == upn_pkg::CLS_DOT) || (cls_q == upn_pkg::CLS_DOTDOT);

  // hex digit decode, either case
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = '0;
    if (byte_q >= upn_pkg::CH_DIG0 && byte_q <= upn_pkg::CH_DIG9) begin
      hex_val = 4'(byte_q - upn_pkg::CH_DIG0);
    end else if (byte_q >= upn_pkg::CH_UA && byte_q <= upn_pkg::CH_UF) begin
      hex_val = 4'(byte_q - upn_pkg::HEX_UOFS);
    end else if (byte_q >= upn_pkg::CH_LA && byte_q <= upn_pkg::CH_LF) begin
      hex_val = 4'(byte_q - upn_pkg::HEX_LOFS);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // escape decoder, segment engine and end-of-uri fixup
  always_comb begin
    wpos_d    = wpos_q;
    cur_d     = cur_q;
    depth_d   = depth_q;
    esc_d     = esc_q;
    high_d    = high_q;
    cls_d     = cls_q;
    slashed_d = slashed_q;
    ovf_d     = ovf_q;
    bad_d     = bad_q;
    done_d    = done_q;
    seg_en    = 1'b0;
    seg_b     = byte_q;
    p         = cur_q;
    st_en     = 1'b0;
    st_pos    = wpos_q;
    st_b      = byte_q;
    sk_we     = 1'b0;
    pw_en     = 1'b0;

    // a push after a finished uri opens a new one
    if (cmd_i.accept && !s_mode_i && done_q) begin
      wpos_d    = '0;
      cur_d     = '0;
      depth_d   = '0;
      esc_d     = upn_pkg::ESC_IDLE;
      high_d    = '0;
      cls_d     = upn_pkg::CLS_EMPTY;
      slashed_d = 1'b0;
      ovf_d     = 1'b0;
      bad_d     = 1'b0;
      done_d    = 1'b0;
    end

    // one raw byte
    if (cmd_i.raw_step && !ovf_q) begin
      if (esc_q != upn_pkg::ESC_IDLE && hex_ok) begin
        if (esc_q == upn_pkg::ESC_HIGH) begin
          high_d = hex_val;
          esc_d  = upn_pkg::ESC_LOW;
        end else begin
          esc_d  = upn_pkg::ESC_IDLE;
          seg_en = 1'b1;
          seg_b  = {high_q, hex_val};
        end
      end else begin
        // bad digit drops the escape, byte goes on as raw
        if (esc_q != upn_pkg::ESC_IDLE) begin
          bad_d = 1'b1;
          esc_d = upn_pkg::ESC_IDLE;
        end
        if (byte_q == upn_pkg::CH_PCT) begin
          esc_d = upn_pkg::ESC_HIGH;
        end else begin
          seg_en = 1'b1;
        end
      end

      if (seg_en) begin
        if (seg_b != upn_pkg::CH_SLASH) begin
          // ordinary byte: classify and append
          if (cls_q == upn_pkg::CLS_EMPTY && seg_b == upn_pkg::CH_DOT) begin
            cls_d = upn_pkg::CLS_DOT;
          end else if (cls_q == upn_pkg::CLS_DOT && seg_b == upn_pkg::CH_DOT) begin
            cls_d = upn_pkg::CLS_DOTDOT;
          end else begin
            cls_d = upn_pkg::CLS_OTHER;
          end
          st_en  = 1'b1;
          st_pos = wpos_q;
          st_b   = seg_b;
        end else if (!slashed_q && cls_dots) begin
          // leading dot segment is dropped
          wpos_d = cur_q;
          cls_d  = upn_pkg::CLS_EMPTY;
        end else if (!cls_dots && (slashed_q || cls_q != upn_pkg::CLS_EMPTY) && stk_full) begin
          ovf_d = 1'b1;
        end else begin
          case (cls_q)
            upn_pkg::CLS_DOT: begin
              p = cur_q;
            end
            upn_pkg::CLS_DOTDOT: begin
              if (depth_q != '0) begin
                depth_d = depth_q - 1'b1;
                p       = below_q;
              end else begin
                p = cur_q;
              end
            end
            default: begin
              p = wpos_q;
              if (slashed_q || cls_q != upn_pkg::CLS_EMPTY) begin
                sk_we   = 1'b1;
                depth_d = depth_q + 1'b1;
              end
            end
          endcase
          cur_d     = p;
          st_en     = 1'b1;
          st_pos    = p;
          st_b      = upn_pkg::CH_SLASH;
          slashed_d = 1'b1;
          cls_d     = upn_pkg::CLS_EMPTY;
        end
      end
    end

    // end of uri: open escape and trailing dot segment
    if (cmd_i.finish) begin
      if (esc_q != upn_pkg::ESC_IDLE) begin
        bad_d = 1'b1;
        esc_d = upn_pkg::ESC_IDLE;
      end
      if (!ovf_q && cls_dots) begin
        if (!slashed_q) begin
          wpos_d = cur_q;
        end else if (cls_q == upn_pkg::CLS_DOT) begin
          wpos_d = cur_q + 1'b1;
        end else begin
          if (depth_q != '0) begin
            depth_d = depth_q - 1'b1;
            p       = below_q;
          end else begin
            p = cur_q;
          end
          cur_d  = p;
          st_en  = 1'b1;
          st_pos = p;
          st_b   = upn_pkg::CH_SLASH;
        end
        cls_d = upn_pkg::CLS_EMPTY;
      end
      done_d = 1'b1;
    end

    // store with bounds check
    if (st_en) begin
      if (st_pos >= upn_pkg::POS_W'(upn_pkg::PATH_BYTES)) begin
        ovf_d = 1'b1;
      end else begin
        pw_en  = 1'b1;
        wpos_d = st_pos + 1'b1;
      end
    end
  end

  // path store port
  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      path_mem[st_pos[upn_pkg::PATH_AW-1:0]] <= st_b;
    end
    if (cmd_i.accept) begin
      rd_data_q <= path_mem[rd_addr];
    end
  end

  // segment start stack, entry below the top is fetched at accept
  always_ff @(posedge clk_i) begin
    if (sk_we) begin
      stk_mem[depth_q] <= cur_q;
    end
    if (cmd_i.accept) begin
      below_q <= stk_mem[stk_rd_addr];
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= s_mode_i;
      fin_q   <= s_last_i;
      byte_q  <= in_byte;
      rd_ok_q <= rd_ok;
    end
  end

  // engine state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q    <= '0;
      cur_q     <= '0;
      depth_q   <= '0;
      esc_q     <= upn_pkg::ESC_IDLE;
      high_q    <= '0;
      cls_q     <= upn_pkg::CLS_EMPTY;
      slashed_q <= 1'b0;
      ovf_q     <= 1'b0;
      bad_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      wpos_q    <= wpos_d;
      cur_q     <= cur_d;
      depth_q   <= depth_d;
      esc_q     <= esc_d;
      high_q    <= high_d;
      cls_q     <= cls_d;
      slashed_q <= slashed_d;
      ovf_q     <= ovf_d;
      bad_q     <= bad_d;
      done_q    <= done_d;
    end
  end

  // output word register
  assign out_byte = (mode_q && rd_ok_q) ? rd_data_q : 8'h00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {3'b000, bad_q, ovf_q, upn_pkg::LEN_W'(wpos_q), out_byte};
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  // status
  assign status_o.fin      = fin_q;
  assign status_o.out_free = !out_valid_q || m_ready_i;
  assign status_o.ovf      = ovf_q;
  assign status_o.uri_done = done_q;

endmodule

@@ bench/tb_uri_path_normalizer.sv @@
// tb_uri_path_normalizer: self-checking bench for the uri path normalizer
// predicts every result word from its own model of decoding and dot removal
// depends on upn_pkg and the uri_path_normalizer rtl

module tb_uri_path_normalizer;

  // word kinds carried in tuser
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // about 950 words with their idle gaps, plus one long hold, several times over
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 925;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic       mode;
    logic [7:0] pbyte;
    logic       last;
    logic [9:0] idx;
  } word_t;

  typedef struct packed {
    logic [7:0]  obyte;
    logic [10:0] len;
    logic        ovf;
    logic        bad;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [upn_pkg::IN_DW-1:0] s_tdata = '0;
  logic                      s_tlast = 1'b0;
  logic                      s_tuser = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [upn_pkg::OUT_DW-1:0] m_tdata;

  uri_path_normalizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    // [7:0] path_byte, [17:8] read_index, [23:18] zero
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    // [0] mode
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    // [7:0] out_byte, [18:8] out_length, [19] overflow, [20] bad_escape, [23:21] zero
    .m_axis_tdata_o  (m_tdata)
  );

  // clock and a single reset at the start
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // normalizer model
  // ---------------------------------------------------------------------------
  logic [7:0]  norm_store [upn_pkg::PATH_BYTES];
  logic [10:0] seg_base [upn_pkg::MAX_SEGMENTS];
  logic [10:0] norm_len;
  logic [6:0]  seg_depth;
  logic [1:0]  esc_phase;
  logic [3:0]  esc_hi;
  logic [1:0]  seg_kind;
  logic        seg_slash;
  logic        flag_ovf;
  logic        flag_bad;
  logic        uri_closed;
  // store entries written since reset always form a prefix of this length
  int          stored_top = 0;

  word_t pending_q[$];
  res_t  result_q[$];

  function automatic int hex_val(logic [7:0] c);
    if (c >= upn_pkg::CH_DIG0 && c <= upn_pkg::CH_DIG9) return int'(c - upn_pkg::CH_DIG0);
    if (c >= upn_pkg::CH_UA && c <= upn_pkg::CH_UF) return int'(c - upn_pkg::HEX_UOFS);
    if (c >= upn_pkg::CH_LA && c <= upn_pkg::CH_LF) return int'(c - upn_pkg::HEX_LOFS);
    return -1;
  endfunction

  function automatic void store_byte(logic [10:0] pos, logic [7:0] b);
    if (pos >= upn_pkg::PATH_BYTES) begin
      flag_ovf = 1'b1;
      return;
    end
    norm_store[pos[9:0]] = b;
    norm_len = pos + 11'd1;
    if (int'(pos) >= stored_top) stored_top = int'(pos) + 1;
  endfunction

  // one decoded byte through dot segment removal
  function automatic void seg_feed(logic [7:0] b);
    logic [10:0] cur;
    logic [10:0] p;
    cur = seg_base[seg_depth];
    if (b != upn_pkg::CH_SLASH) begin
      if (seg_kind == upn_pkg::CLS_EMPTY && b == upn_pkg::CH_DOT) seg_kind = upn_pkg::CLS_DOT;
      else if (seg_kind == upn_pkg::CLS_DOT && b == upn_pkg::CH_DOT)
        seg_kind = upn_pkg::CLS_DOTDOT;
      else seg_kind = upn_pkg::CLS_OTHER;
      store_byte(norm_len, b);
      return;
    end
    // leading dot or dot-dot segment is dropped
    if (!seg_slash && (seg_kind == upn_pkg::CLS_DOT || seg_kind == upn_pkg::CLS_DOTDOT)) begin
      norm_len = cur;
      seg_kind = upn_pkg::CLS_EMPTY;
      return;
    end
    if (seg_kind == upn_pkg::CLS_DOT) begin
      p = cur;
    end else if (seg_kind == upn_pkg::CLS_DOTDOT) begin
      if (seg_depth > 0) begin
        seg_depth = seg_depth - 7'd1;
        p = seg_base[seg_depth];
      end else begin
        p = cur;
      end
    end else if (!seg_slash && seg_kind == upn_pkg::CLS_EMPTY) begin
      p = norm_len;
    end else begin
      if (int'(seg_depth) + 1 >= upn_pkg::MAX_SEGMENTS) begin
        flag_ovf = 1'b1;
        return;
      end
      seg_depth = seg_depth + 7'd1;
      p = norm_len;
    end
    seg_base[seg_depth] = p;
    store_byte(p, upn_pkg::CH_SLASH);
    seg_slash = 1'b1;
    seg_kind = upn_pkg::CLS_EMPTY;
  endfunction

  // percent decoding in front of the segment logic
  function automatic void raw_feed(logic [7:0] b);
    int v;
    if (esc_phase != upn_pkg::ESC_IDLE) begin
      v = hex_val(b);
      if (v >= 0) begin
        if (esc_phase == upn_pkg::ESC_HIGH) begin
          esc_hi = v[3:0];
          esc_phase = upn_pkg::ESC_LOW;
        end else begin
          esc_phase = upn_pkg::ESC_IDLE;
          seg_feed({esc_hi, v[3:0]});
        end
        return;
      end
      flag_bad = 1'b1;
      esc_phase = upn_pkg::ESC_IDLE;
    end
    if (b == upn_pkg::CH_PCT) begin
      esc_phase = upn_pkg::ESC_HIGH;
      return;
    end
    seg_feed(b);
  endfunction

  // end of uri: open escape and trailing dot segments
  function automatic void uri_close();
    logic [10:0] cur;
    logic [10:0] p;
    cur = seg_base[seg_depth];
    if (esc_phase != upn_pkg::ESC_IDLE) begin
      flag_bad = 1'b1;
      esc_phase = upn_pkg::ESC_IDLE;
    end
    if (flag_ovf) return;
    if (seg_kind != upn_pkg::CLS_DOT && seg_kind != upn_pkg::CLS_DOTDOT) return;
    if (!seg_slash) begin
      norm_len = cur;
    end else if (seg_kind == upn_pkg::CLS_DOT) begin
      norm_len = cur + 11'd1;
    end else begin
      if (seg_depth > 0) begin
        seg_depth = seg_depth - 7'd1;
        p = seg_base[seg_depth];
      end else begin
        p = cur;
      end
      seg_base[seg_depth] = p;
      store_byte(p, upn_pkg::CH_SLASH);
    end
    seg_kind = upn_pkg::CLS_EMPTY;
  endfunction

  function automatic void uri_open();
    norm_len = '0;
    seg_depth = '0;
    seg_base[0] = '0;
    esc_phase = upn_pkg::ESC_IDLE;
    esc_hi = '0;
    seg_kind = upn_pkg::CLS_EMPTY;
    seg_slash = 1'b0;
    flag_ovf = 1'b0;
    flag_bad = 1'b0;
    uri_closed = 1'b0;
  endfunction

  // expected result of one accepted word, if it has one
  function automatic void predict_word(word_t w);
    res_t r;
    r.obyte = '0;
    if (w.mode == MODE_PUSH) begin
      if (uri_closed) uri_open();
      if (!flag_ovf) raw_feed(w.pbyte);
      if (!w.last) return;
      uri_close();
      uri_closed = 1'b1;
    end else begin
      r.obyte = norm_store[w.idx];
    end
    r.len = norm_len;
    r.ovf = flag_ovf;
    r.bad = flag_bad;
    result_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // idle gaps: mostly short, a few long, with calm stretches of none
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------
  word_t cur_word;
  logic  src_took;
  int    src_gap = 0;
  int    src_calm = 0;
  int    words_taken = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      src_took = s_tvalid && s_tready;
      if (src_took) begin
        predict_word(cur_word);
        words_taken++;
      end
      if (!s_tvalid || src_took) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_word = pending_q.pop_front();
          // reads only reach bytes already written since reset
          if (cur_word.mode == MODE_READ && stored_top > 0)
            cur_word.idx = 10'(int'(cur_word.idx) % stored_top);
          s_tdata  <= {{(upn_pkg::IN_DW - upn_pkg::IDX_LSB - upn_pkg::IDX_W){1'b0}},
                       cur_word.idx, cur_word.pbyte};
          s_tlast  <= cur_word.last;
          s_tuser  <= cur_word.mode;
          s_tvalid <= 1'b1;
          if (src_calm > 0) src_calm--;
          else if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(20, 80);
          src_gap = (src_calm > 0) ? 0 : gap_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and checker
  // ---------------------------------------------------------------------------
  logic sink_hold = 1'b0;
  res_t got;
  res_t want;
  int   snk_gap = 0;
  int   snk_calm = 0;
  int   fail_count = 0;
  int   results_checked = 0;
  int   ovf_results = 0;
  int   bad_results = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.obyte = m_tdata[upn_pkg::BYTE_W-1:0];
        got.len   = m_tdata[upn_pkg::LEN_LSB +: upn_pkg::LEN_W];
        got.ovf   = m_tdata[upn_pkg::OVF_BIT];
        got.bad   = m_tdata[upn_pkg::BAD_BIT];
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          want = result_q.pop_front();
          results_checked++;
          if (want.ovf) ovf_results++;
          if (want.bad) bad_results++;
          if (got.obyte != want.obyte || got.len != want.len ||
              got.ovf != want.ovf || got.bad != want.bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: byte %h/%h len %0d/%0d ovf %b/%b bad %b/%b (exp/got)",
                       results_checked, want.obyte, got.obyte, want.len, got.len,
                       want.ovf, got.ovf, want.bad, got.bad);
          end
        end
      end
      // receiver readiness
      if (sink_hold) begin
        m_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else begin
        if (snk_calm > 0) snk_calm--;
        else if ($urandom_range(0, 49) == 0) snk_calm = $urandom_range(20, 80);
        snk_gap = (snk_calm > 0) ? 0 : gap_len();
        m_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  int hold_at = 32'h7fffffff;
  int hold_cnt = 0;

  initial begin
    while (words_taken < hold_at) @(negedge clk_i);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    while (hold_cnt < HOLD_CYCLES) begin
      @(posedge clk_i);
      hold_cnt++;
    end
    sink_hold <= 1'b0;
  end

  // run limit
  int cycle_cnt = 0;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("uri_path_normalizer: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [7:0] uri_q[$];
  int words_sent = 0;
  int uris_sent = 0;

  task automatic send_word(logic mode, logic [7:0] b, logic last, logic [9:0] idx);
    word_t w;
    w.mode = mode;
    w.pbyte = b;
    w.last = last;
    w.idx = idx;
    pending_q.push_back(w);
    words_sent++;
  endtask

  function automatic logic [9:0] rand_idx();
    if ($urandom_range(0, 9) < 6) return 10'($urandom_range(0, 40));
    return 10'($urandom_range(0, upn_pkg::PATH_BYTES - 1));
  endfunction

  // read words carry random path_byte and tlast, which the block ignores
  task automatic send_read(logic [9:0] idx);
    send_word(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) uri_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(int v, bit upper);
    if (v < 10) return 8'(int'(upn_pkg::CH_DIG0) + v);
    return 8'(int'(upper ? upn_pkg::CH_UA : upn_pkg::CH_LA) + v - 10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_val(c) >= 0);
    return c;
  endfunction

  // pushes the collected uri, tlast on its final byte
  task automatic emit_uri(bit mid_reads);
    for (int i = 0; i < uri_q.size(); i++) begin
      send_word(MODE_PUSH, uri_q[i], i == uri_q.size() - 1, 10'($urandom_range(0, 1023)));
      if (mid_reads && $urandom_range(0, 9) == 0) send_read(rand_idx());
    end
    uri_q.delete();
    uris_sent++;
  endtask

  task automatic add_token();
    case ($urandom_range(0, 11))
      0:  add_str("/");
      1:  add_str(".");
      2:  add_str("..");
      3:  repeat ($urandom_range(1, 3)) uri_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
      4:  begin add_str("%2"); uri_q.push_back($urandom_range(0, 1) ? "E" : "e"); end
      5:  begin add_str("%2"); uri_q.push_back($urandom_range(0, 1) ? "F" : "f"); end
      6:  begin
            uri_q.push_back(upn_pkg::CH_PCT);
            uri_q.push_back(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
            uri_q.push_back(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
          end
      7:  begin
            // bad escape, digit missing or not hex
            uri_q.push_back(upn_pkg::CH_PCT);
            if ($urandom_range(0, 1))
              uri_q.push_back(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
            uri_q.push_back(non_hex());
          end
      8:  uri_q.push_back(8'($urandom_range(0, 255)));
      9:  add_str("/.");
      10: add_str("/..");
      default: add_str("./");
    endcase
  endtask

  task automatic gen_uri();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      // more segments than the stack holds
      repeat (upn_pkg::MAX_SEGMENTS) add_str("/a");
      add_str("/b");
    end else if (r < 17) begin
      repeat ($urandom_range(1, 12)) uri_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) add_token();
      // escape cut short by the end of the uri
      r = $urandom_range(0, 19);
      if (r == 0) begin
        uri_q.push_back(upn_pkg::CH_PCT);
      end else if (r == 1) begin
        uri_q.push_back(upn_pkg::CH_PCT);
        uri_q.push_back(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
      end
    end
    emit_uri(1'b1);
    repeat ($urandom_range(0, 3)) send_read(rand_idx());
  endtask

  int random_base;

  initial begin
    for (int i = 0; i < upn_pkg::PATH_BYTES; i++) norm_store[i] = '0;
    for (int i = 0; i < upn_pkg::MAX_SEGMENTS; i++) seg_base[i] = '0;
    uri_open();

    // directed: leading and trailing dots, dot-dot, a read in flight
    add_str("./a/../b/.");
    emit_uri(1'b0);
    send_read(10'd0);
    send_read(10'd1023);
    // bad hex digit, then escape open at the final byte
    add_str("%4g/%");
    emit_uri(1'b0);
    // mixed-case escape decoding to the top byte value
    add_str("%fF");
    emit_uri(1'b0);
    add_str("/..");
    emit_uri(1'b0);
    send_read(10'd5);

    // random uris, the long hold lands early in this part
    random_base = words_sent;
    hold_at = words_sent + 40;
    while (words_sent - random_base < RANDOM_WORDS) gen_uri();

    while (pending_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (result_q.size() != 0) begin
      fail_count += result_q.size();
      $display("%0d expected results never arrived", result_q.size());
    end

    $display("covered %0d uris in %0d words, %0d results checked", uris_sent, words_taken,
             results_checked);
    $display("results with overflow %0d, with bad escape %0d, failures %0d", ovf_results,
             bad_results, fail_count);
    if (fail_count == 0) begin
      $display("uri_path_normalizer: match");
    end else begin
      $display("uri_path_normalizer: mismatch");
    end
    $finish;
  end

endmodule
